// File: rtl/stbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_pkg
// Shared widths, defaults, opcodes and controller/datapath interface types
// for the suffix trie best match unit.
// ----------------------------------------------------------------------------
package stbm_pkg;

    localparam int LETTER_W = 5;
    localparam int IDX_W    = 10;
    localparam int LEN_W    = 10;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int ALPHABET_DEF   = 26;
    localparam int MAX_WORDS_DEF  = 1024;
    localparam int MAX_LENGTH_DEF = 1023;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic clear_step;   // write one zero entry of the child table
        logic load;         // capture the item and start the table read
        logic exec;         // apply the item to the trie state
    } cmd_t;

    typedef struct packed {
        logic clear_done;   // last entry of the clearing pass
        logic out_blocked;  // result register full and stalled
    } stat_t;

endpackage

// File: rtl/suffix_trie_best_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_trie_best_match_unit
// Suffix trie over a fixed node pool; reports the shortest word, lowest index
// on a tie, sharing the longest suffix with each query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one letter per transfer,
//   dictionary words and queries alike given last letter first; last marks
//   the final letter of a word or query. opcode selects insert or query.
//   Output channel (out_valid / out_stall) carries one result per query
//   letter with last set: best_index and the sticky pool_full flag.
//   Each letter is handled as one child-table read, then the update and
//   write back on the same single-port table, so in_stall is high in the
//   cycle after each transfer. A result is written to the result register
//   in the update step of its letter.
//   After reset all NODE_COUNT * ALPHABET entries of the child table (106496
//   by default) are cleared one entry a cycle; in_stall stays high
//   meanwhile. The result register holds while out_stall is high; the next
//   letter is still taken, but its update waits, with in_stall high, until
//   that result has been transferred.
// ----------------------------------------------------------------------------
module suffix_trie_best_match_unit
#(
    parameter int NODE_COUNT = stbm_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET   = stbm_pkg::ALPHABET_DEF,
    parameter int MAX_WORDS  = stbm_pkg::MAX_WORDS_DEF,
    parameter int MAX_LENGTH = stbm_pkg::MAX_LENGTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [stbm_pkg::LETTER_W-1:0] letter,
    input  logic [stbm_pkg::IDX_W-1:0]    word_index,
    input  logic [stbm_pkg::LEN_W-1:0]    word_length,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stbm_pkg::IDX_W-1:0]    best_index,
    output logic                          pool_full
);

    stbm_pkg::cmd_t  cmd;
    stbm_pkg::stat_t stat;

    stbm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    stbm_datapath
    #(
        .NODE_COUNT (NODE_COUNT),
        .ALPHABET   (ALPHABET),
        .MAX_WORDS  (MAX_WORDS),
        .MAX_LENGTH (MAX_LENGTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .letter      (letter),
        .word_index  (word_index),
        .word_length (word_length),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_index  (best_index),
        .pool_full   (pool_full)
    );

endmodule

// File: rtl/stbm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_ctrl
// Sequencer: clearing pass after reset, then one item at a time in two steps
// (table read, then update).
// ----------------------------------------------------------------------------
module stbm_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output stbm_pkg::cmd_t cmd,
    input  stbm_pkg::stat_t stat
);

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.clear_step = 1'b0;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold while a finished result has not been taken
                if (!stat.out_blocked)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// File: rtl/stbm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_datapath
// Child table memory (each slot also carries the best word of the node it
// points to), cursor, root best, pool allocator and result register.
// ----------------------------------------------------------------------------
module stbm_datapath
#(
    parameter int NODE_COUNT = stbm_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET   = stbm_pkg::ALPHABET_DEF,
    parameter int MAX_WORDS  = stbm_pkg::MAX_WORDS_DEF,
    parameter int MAX_LENGTH = stbm_pkg::MAX_LENGTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  stbm_pkg::cmd_t                cmd,
    output stbm_pkg::stat_t               stat,
    input  logic                          opcode,
    input  logic [stbm_pkg::LETTER_W-1:0] letter,
    input  logic [stbm_pkg::IDX_W-1:0]    word_index,
    input  logic [stbm_pkg::LEN_W-1:0]    word_length,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stbm_pkg::IDX_W-1:0]    best_index,
    output logic                          pool_full
);

    localparam int IDX_W      = stbm_pkg::IDX_W;
    localparam int LEN_W      = stbm_pkg::LEN_W;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = $clog2(NODE_COUNT + 1);
    localparam int SLOT_DEPTH = NODE_COUNT * ALPHABET;
    localparam int SLOT_W     = $clog2(SLOT_DEPTH);
    localparam int ENTRY_W    = NODE_W + IDX_W + LEN_W;

    function automatic logic is_better(
        input logic [IDX_W-1:0] idx,
        input logic [LEN_W-1:0] len,
        input logic [IDX_W-1:0] held_idx,
        input logic [LEN_W-1:0] held_len
    );
        is_better = (len < held_len) || ((len == held_len) && (idx < held_idx));
    endfunction

    // child table: {child node, best index of child, best length of child}
    logic [ENTRY_W-1:0] child_mem [SLOT_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    logic [NODE_W-1:0]  rd_child;
    logic [IDX_W-1:0]   rd_idx;
    logic [LEN_W-1:0]   rd_len;

    // captured item
    logic               op_reg;
    logic               last_reg;
    logic               letter_ok_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [IDX_W-1:0]   idx_clamped;
    logic [LEN_W-1:0]   len_clamped;
    logic [SLOT_W-1:0]  slot_next;

    // trie control state
    logic [NODE_W-1:0]  cursor_reg,    cursor_next;
    logic [IDX_W-1:0]   cur_idx_reg,   cur_idx_next;
    logic               stopped_reg,   stopped_next;
    logic               root_valid_reg, root_valid_next;
    logic [IDX_W-1:0]   root_idx_reg,  root_idx_next;
    logic [LEN_W-1:0]   root_len_reg,  root_len_next;
    logic [FREE_W-1:0]  free_reg,      free_next;
    logic               full_reg,      full_next;
    logic [SLOT_W-1:0]  clr_cnt_reg,   clr_cnt_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_full_reg;
    logic               result_set;
    logic [IDX_W-1:0]   result_idx;

    assign rd_child = rd_data_reg[ENTRY_W-1 -: NODE_W];
    assign rd_idx   = rd_data_reg[LEN_W +: IDX_W];
    assign rd_len   = rd_data_reg[LEN_W-1:0];

    assign idx_clamped = (32'(word_index) > MAX_WORDS - 1) ? IDX_W'(MAX_WORDS - 1)
                                                            : word_index;
    assign len_clamped = (32'(word_length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH)
                                                          : word_length;
    assign slot_next   = SLOT_W'(cursor_reg) * SLOT_W'(ALPHABET) + SLOT_W'(letter);

    assign stat.clear_done  = (clr_cnt_reg == SLOT_W'(SLOT_DEPTH - 1));
    assign stat.out_blocked = out_valid_reg && out_stall;

    always_comb
    begin
        cursor_next     = cursor_reg;
        cur_idx_next    = cur_idx_reg;
        stopped_next    = stopped_reg;
        root_valid_next = root_valid_reg;
        root_idx_next   = root_idx_reg;
        root_len_next   = root_len_reg;
        free_next       = free_reg;
        full_next       = full_reg;
        clr_cnt_next    = clr_cnt_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = {rd_child, idx_reg, len_reg};
        result_set      = 1'b0;
        result_idx      = root_idx_reg;

        if (cmd.clear_step)
        begin
            mem_we       = 1'b1;
            mem_waddr    = clr_cnt_reg;
            mem_wdata    = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (cmd.exec)
        begin
            if (op_reg == stbm_pkg::OP_INSERT)
            begin
                // root best follows every insert letter, even ignored ones
                if (!root_valid_reg ||
                    is_better(idx_reg, len_reg, root_idx_reg, root_len_reg))
                begin
                    root_valid_next = 1'b1;
                    root_idx_next   = idx_reg;
                    root_len_next   = len_reg;
                end
                if (!stopped_reg)
                begin
                    if (!letter_ok_reg)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (rd_child == '0)
                    begin
                        if (32'(free_reg) >= NODE_COUNT)
                        begin
                            full_next    = 1'b1;
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            // allocate a fresh node
                            mem_we       = 1'b1;
                            mem_wdata    = {free_reg[NODE_W-1:0], idx_reg, len_reg};
                            cursor_next  = free_reg[NODE_W-1:0];
                            cur_idx_next = idx_reg;
                            free_next    = free_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cursor_next = rd_child;
                        if (is_better(idx_reg, len_reg, rd_idx, rd_len))
                        begin
                            mem_we       = 1'b1;
                            cur_idx_next = idx_reg;
                        end
                        else
                        begin
                            cur_idx_next = rd_idx;
                        end
                    end
                end
            end
            else
            begin
                if (!stopped_reg)
                begin
                    if (!letter_ok_reg || (rd_child == '0))
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        cursor_next  = rd_child;
                        cur_idx_next = rd_idx;
                    end
                end
                if (last_reg)
                begin
                    result_set = 1'b1;
                    result_idx = (cursor_next == '0) ? root_idx_reg : cur_idx_next;
                end
            end

            if (last_reg)
            begin
                cursor_next  = '0;
                stopped_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        if (result_set)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            child_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.load)
        begin
            rd_data_reg <= child_mem[slot_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= opcode;
            last_reg      <= last;
            letter_ok_reg <= (32'(letter) < ALPHABET);
            idx_reg       <= idx_clamped;
            len_reg       <= len_clamped;
            slot_reg      <= slot_next;
        end
        cur_idx_reg  <= cur_idx_next;
        root_idx_reg <= root_idx_next;
        root_len_reg <= root_len_next;
        if (result_set)
        begin
            out_idx_reg  <= result_idx;
            out_full_reg <= full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            stopped_reg    <= 1'b0;
            root_valid_reg <= 1'b0;
            free_reg       <= FREE_W'(1);
            full_reg       <= 1'b0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg     <= cursor_next;
            stopped_reg    <= stopped_next;
            root_valid_reg <= root_valid_next;
            free_reg       <= free_next;
            full_reg       <= full_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_index = out_idx_reg;
    assign pool_full  = out_full_reg;

endmodule
